// ----- rtl/interphoton_gap_burst_search_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the interphoton gap burst search
// Concurrent checks, left out when synthesising.
// ---------------------------------------------------------------------------
`ifndef INTERPHOTON_GAP_BURST_SEARCH_MACROS_SVH
`define INTERPHOTON_GAP_BURST_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every edge out of reset
`define IGBS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("igbs assertion failed");

// antecedent implies consequent in the same cycle
`define IGBS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("igbs assertion failed");

// antecedent implies consequent in the next cycle
`define IGBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("igbs assertion failed");

`else

`define IGBS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define IGBS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define IGBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/igbs_pkg.sv -----
// ---------------------------------------------------------------------------
// igbs_pkg
// Shared types and constants of the interphoton gap burst search.
// ---------------------------------------------------------------------------
package igbs_pkg;

    // one burst report
    typedef struct packed {
        logic [31:0] burst_start;
        logic [31:0] burst_stop;
        logic [31:0] burst_ordinal;
        logic        final_of_item;
    } t_result;

    // result queue geometry (power of two depth)
    localparam int unsigned ResultDepth = 4;
    localparam int unsigned PtrBits     = 2;
    localparam int unsigned CountBits   = 3;

    // push request into the result queue: zero, one or two results
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // queue status back to the search logic
    typedef struct packed {
        logic room_for_two;
    } t_fifo_status;

    // configuration register map
    localparam int unsigned CfgIndexBits = 8;
    localparam logic [CfgIndexBits-1:0] RegMaxGap  = 8'd0;
    localparam logic [CfgIndexBits-1:0] RegMinSize = 8'd1;

    localparam logic [31:0] MaxGapReset  = 32'd500;
    localparam logic [31:0] MinSizeReset = 32'd10;

endpackage

// ----- rtl/interphoton_gap_burst_search.sv -----
// ---------------------------------------------------------------------------
// interphoton_gap_burst_search
// Burst search over a stream of photon arrival times by interphoton gap.
// ---------------------------------------------------------------------------
// One photon timestamp is taken per request. A run goes on while the wrapping
// 64-bit gap to the previous photon is at most max_gap; a larger gap, or the
// end-of-stream flag, closes the run, and a closed run of at least
// min_size photons is reported as [burst_start, burst_stop) with its
// ordinal in the stream. A photon yields zero, one or two reports; the last
// one of a photon carries final_of_item. Throughput is one photon per cycle
// while each photon yields at most one report and the output is not stalled;
// the gap subtract, the two length compares and the state update all sit
// in the cycle of acceptance. Reports go into a four-entry result queue that
// drains one per cycle while not stalled. Input is stalled whenever fewer
// than two queue entries are free, i.e. with three or four reports waiting;
// each photon that yields two reports adds one to the backlog, so a steady
// run of such photons stalls the input even with a free output. A report is
// written into the result queue when its photon is accepted.
// After end_of_stream all stream state returns to reset and the next photon
// starts a new stream. Configuration writes are always ready and belong in
// idle periods only.
// ---------------------------------------------------------------------------
`include "interphoton_gap_burst_search_macros.svh"

module interphoton_gap_burst_search #(
    parameter int unsigned INDEX_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // photon requests
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [63:0]                          i_arrival_time,
    input  logic                                 i_end_of_stream,

    // burst reports
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [31:0]                          o_burst_start,
    output logic [31:0]                          o_burst_stop,
    output logic [31:0]                          o_burst_ordinal,
    output logic                                 o_final_of_item,

    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [igbs_pkg::CfgIndexBits-1:0]    i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);

    // length arithmetic wide enough for both an index and min_size
    localparam int unsigned LenBits = (INDEX_BITS > 32) ? INDEX_BITS : 32;

    // configuration
    logic [31:0]           r_max_gap;
    logic [31:0]           r_min_size;

    // stream state
    logic [63:0]           r_previous_time;
    logic                  r_have_previous;
    logic [INDEX_BITS-1:0] r_run_begin;
    logic [INDEX_BITS-1:0] r_photon_index;
    logic [31:0]           r_bursts_found;

    logic                  accept;
    logic [63:0]           gap;
    logic                  gap_breaks;
    logic [INDEX_BITS-1:0] index_next;
    logic [INDEX_BITS-1:0] begin_after_gap;
    logic [LenBits-1:0]    gap_run_len;
    logic [LenBits-1:0]    end_run_len;
    logic [LenBits-1:0]    min_len;
    logic                  emit_gap;
    logic                  emit_end;
    logic [31:0]           ordinal_end;
    logic [31:0]           n_bursts_found;

    igbs_pkg::t_result      res_gap;
    igbs_pkg::t_result      res_end;
    igbs_pkg::t_result      head;
    igbs_pkg::t_push        push;
    igbs_pkg::t_fifo_status fifo_status;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == '1) ? v : v + 32'd1;
    endfunction

    assign o_stall = !fifo_status.room_for_two;
    assign accept  = i_valid && !o_stall;

    // --- gap test and run bookkeeping --------------------------------------
    always_comb begin
        gap        = i_arrival_time - r_previous_time;     // wraps mod 2^64
        gap_breaks = r_have_previous && (gap > {32'd0, r_max_gap});

        // index saturates at all ones
        index_next = (r_photon_index == '1) ? r_photon_index
                                            : r_photon_index + INDEX_BITS'(1);

        min_len     = LenBits'(r_min_size);
        gap_run_len = LenBits'(r_photon_index) - LenBits'(r_run_begin);
        emit_gap    = gap_breaks && (gap_run_len >= min_len);

        // a breaking gap opens a new run at this photon
        begin_after_gap = gap_breaks ? r_photon_index : r_run_begin;
        end_run_len     = LenBits'(index_next) - LenBits'(begin_after_gap);
        emit_end        = i_end_of_stream && (end_run_len >= min_len);

        ordinal_end    = emit_gap ? sat_inc32(r_bursts_found) : r_bursts_found;
        n_bursts_found = emit_end ? sat_inc32(ordinal_end) : ordinal_end;
    end

    // --- reports ------------------------------------------------------------
    always_comb begin
        res_gap.burst_start   = 32'(r_run_begin);
        res_gap.burst_stop    = 32'(r_photon_index);
        res_gap.burst_ordinal = r_bursts_found;
        res_gap.final_of_item = !emit_end;

        res_end.burst_start   = 32'(begin_after_gap);
        res_end.burst_stop    = 32'(index_next);
        res_end.burst_ordinal = ordinal_end;
        res_end.final_of_item = 1'b1;

        push.count  = accept ? (2'(emit_gap) + 2'(emit_end)) : 2'd0;
        push.first  = emit_gap ? res_gap : res_end;
        push.second = res_end;
    end

    // --- state --------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap       <= igbs_pkg::MaxGapReset;
            r_min_size      <= igbs_pkg::MinSizeReset;
            r_previous_time <= '0;
            r_have_previous <= 1'b0;
            r_run_begin     <= '0;
            r_photon_index  <= '0;
            r_bursts_found  <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    igbs_pkg::RegMaxGap:  r_max_gap  <= i_cfg_data;
                    igbs_pkg::RegMinSize: r_min_size <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_end_of_stream) begin
                    // stream closed: back to a fresh stream
                    r_previous_time <= '0;
                    r_have_previous <= 1'b0;
                    r_run_begin     <= '0;
                    r_photon_index  <= '0;
                    r_bursts_found  <= '0;
                end else begin
                    r_previous_time <= i_arrival_time;
                    r_have_previous <= 1'b1;
                    r_run_begin     <= begin_after_gap;
                    r_photon_index  <= index_next;
                    r_bursts_found  <= n_bursts_found;
                end
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // --- result queue -------------------------------------------------------
    igbs_result_fifo u_result_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_status (fifo_status),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (head)
    );

    assign o_burst_start   = head.burst_start;
    assign o_burst_stop    = head.burst_stop;
    assign o_burst_ordinal = head.burst_ordinal;
    assign o_final_of_item = head.final_of_item;

    `IGBS_ASSERT_ALWAYS(a_run_within_index, i_clk, i_rst_n,
        r_run_begin <= r_photon_index)
    `IGBS_ASSERT_NEXT(a_stream_clears, i_clk, i_rst_n,
        accept && i_end_of_stream,
        (r_photon_index == '0) && !r_have_previous && (r_bursts_found == '0))
    `IGBS_ASSERT_IMPLIES(a_first_photon_no_gap, i_clk, i_rst_n,
        accept && !r_have_previous, (push.count == 2'd0) || !emit_gap)

endmodule

// ----- rtl/igbs_result_fifo.sv -----
// ---------------------------------------------------------------------------
// igbs_result_fifo
// Small register queue of burst reports; takes up to two per cycle and
// hands out one per cycle on a valid/stall port.
// ---------------------------------------------------------------------------
`include "interphoton_gap_burst_search_macros.svh"

module igbs_result_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  igbs_pkg::t_push         i_push,
    output igbs_pkg::t_fifo_status  o_status,
    output logic                    o_valid,
    input  logic                    i_stall,
    output igbs_pkg::t_result       o_result
);

    igbs_pkg::t_result r_entry [igbs_pkg::ResultDepth];

    logic [igbs_pkg::PtrBits-1:0]   r_wr_ptr;
    logic [igbs_pkg::PtrBits-1:0]   r_rd_ptr;
    logic [igbs_pkg::CountBits-1:0] r_count;

    logic [igbs_pkg::PtrBits-1:0]   n_wr_ptr;
    logic [igbs_pkg::PtrBits-1:0]   n_rd_ptr;
    logic [igbs_pkg::CountBits-1:0] n_count;
    logic [igbs_pkg::PtrBits-1:0]   wr_ptr_plus1;
    logic                           pop;

    assign pop          = (r_count != '0) && !i_stall;
    assign wr_ptr_plus1 = r_wr_ptr + igbs_pkg::PtrBits'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + igbs_pkg::PtrBits'(i_push.count);
        n_rd_ptr = pop ? r_rd_ptr + igbs_pkg::PtrBits'(1) : r_rd_ptr;
        n_count  = r_count + igbs_pkg::CountBits'(i_push.count)
                 - igbs_pkg::CountBits'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_entry[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_entry[wr_ptr_plus1] <= i_push.second;
        end
    end

    assign o_valid               = (r_count != '0);
    assign o_result              = r_entry[r_rd_ptr];
    assign o_status.room_for_two =
        (r_count <= igbs_pkg::CountBits'(igbs_pkg::ResultDepth - 2));

    `IGBS_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n,
        r_count <= igbs_pkg::CountBits'(igbs_pkg::ResultDepth))
    `IGBS_ASSERT_IMPLIES(a_double_push_room, i_clk, i_rst_n,
        i_push.count == 2'd2, r_count <= igbs_pkg::CountBits'(igbs_pkg::ResultDepth - 2))
    `IGBS_ASSERT_NEXT(a_pop_only_drains, i_clk, i_rst_n,
        pop && (i_push.count == 2'd0), r_count == $past(r_count) - 1'b1)

endmodule

// ----- tb/interphoton_gap_burst_search_tb.sv -----
// ---------------------------------------------------------------------------
// interphoton_gap_burst_search_tb
// Self-checking bench for the gap-based photon burst search: photon requests
// are driven in random bursts against a randomly stalling report side, every
// accepted photon is run through a bit-exact predictor of the search, and each
// report is compared field by field with the oldest predicted burst.
// ---------------------------------------------------------------------------
module interphoton_gap_burst_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 400000;  // far above the slowest correct run
    localparam int SETTLE_CYCLES    = 4;       // spare cycles at the end of wait_drained
    localparam int LONG_HOLD_CYCLES = 200;

    typedef struct {
        logic [63:0] arrival;
        logic        eos;
    } t_photon;

    // clock, reset and DUT ports; every input known from time zero
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [63:0] i_arrival_time  = 64'd0;
    logic        i_end_of_stream = 1'b0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [31:0] o_burst_start;
    logic [31:0] o_burst_stop;
    logic [31:0] o_burst_ordinal;
    logic        o_final_of_item;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [igbs_pkg::CfgIndexBits-1:0] i_cfg_index = igbs_pkg::RegMaxGap;
    logic [31:0] i_cfg_data      = 32'd0;

    // photons waiting to be offered, bursts waiting to be reported
    t_photon           pending_photons[$];
    igbs_pkg::t_result expected_bursts[$];

    int error_count = 0;
    int cycle_count = 0;

    // predictor copy of the search state and its thresholds
    logic [63:0]       pred_prev_time;
    logic              pred_have_prev;
    logic [31:0]       pred_run_begin;
    logic [31:0]       pred_photon_idx;
    logic [31:0]       pred_bursts_found;
    logic [31:0]       cfg_max_gap;
    logic [31:0]       cfg_min_size;
    igbs_pkg::t_result head_burst;

    // stimulus generation state
    logic [63:0] gen_time    = 64'd0;
    logic [31:0] gen_max_gap = igbs_pkg::MaxGapReset;
    logic [31:0] gen_min     = igbs_pkg::MinSizeReset;
    int          phase_count = 0;

    // sender burst/gap shaping
    int      burst_left = 0;
    int      send_gap   = 0;
    t_photon next_photon;

    // receiver stall pattern and the long hold-off
    int hold_ticket  = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int pattern_left = 0;

    interphoton_gap_burst_search DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_arrival_time  (i_arrival_time),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_burst_start   (o_burst_start),
        .o_burst_stop    (o_burst_stop),
        .o_burst_ordinal (o_burst_ordinal),
        .o_final_of_item (o_final_of_item),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // queue a burst for the closed run [start, stop) if it is long enough
    task automatic close_run(input logic [31:0] start, input logic [31:0] stop);
        igbs_pkg::t_result r;
        if (stop - start >= cfg_min_size) begin
            r.burst_start   = start;
            r.burst_stop    = stop;
            r.burst_ordinal = pred_bursts_found;
            r.final_of_item = 1'b0;
            expected_bursts.push_back(r);
            if (pred_bursts_found != 32'hFFFF_FFFF)
                pred_bursts_found = pred_bursts_found + 32'd1;
        end
    endtask

    // one accepted photon: gap check, index advance, end-of-stream close
    task automatic track_photon(input logic [63:0] t, input logic eos);
        logic [31:0]       idx;
        logic [31:0]       nxt;
        logic [63:0]       gap;
        int                depth_before;
        igbs_pkg::t_result r;
        depth_before = expected_bursts.size();
        idx = pred_photon_idx;
        nxt = (idx != 32'hFFFF_FFFF) ? idx + 32'd1 : idx;   // index saturates
        gap = t - pred_prev_time;                          // wraps modulo 2^64
        if (pred_have_prev && gap > {32'd0, cfg_max_gap}) begin
            close_run(pred_run_begin, idx);
            pred_run_begin = idx;
        end
        pred_prev_time  = t;
        pred_have_prev  = 1'b1;
        pred_photon_idx = nxt;
        if (eos) begin
            close_run(pred_run_begin, nxt);
            pred_prev_time    = 64'd0;
            pred_have_prev    = 1'b0;
            pred_run_begin    = 32'd0;
            pred_photon_idx   = 32'd0;
            pred_bursts_found = 32'd0;
        end
        // last report of this photon carries the flag
        if (expected_bursts.size() > depth_before) begin
            r = expected_bursts.pop_back();
            r.final_of_item = 1'b1;
            expected_bursts.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // -----------------------------------------------------------------------
    // Monitor: config writes, accepted photons and reports, all sampled at
    // the rising edge. Predict before checking so ordering never matters.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pred_prev_time    = 64'd0;
            pred_have_prev    = 1'b0;
            pred_run_begin    = 32'd0;
            pred_photon_idx   = 32'd0;
            pred_bursts_found = 32'd0;
            cfg_max_gap       = igbs_pkg::MaxGapReset;
            cfg_min_size      = igbs_pkg::MinSizeReset;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    igbs_pkg::RegMaxGap:  cfg_max_gap  = i_cfg_data;
                    igbs_pkg::RegMinSize: cfg_min_size = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                track_photon(i_arrival_time, i_end_of_stream);
            if (o_valid && !i_stall) begin
                if (expected_bursts.size() == 0) begin
                    $error("unexpected burst report: start %0d stop %0d ordinal %0d",
                           o_burst_start, o_burst_stop, o_burst_ordinal);
                    error_count++;
                end else begin
                    head_burst = expected_bursts.pop_front();
                    check_field("burst_start", head_burst.burst_start, o_burst_start);
                    check_field("burst_stop", head_burst.burst_stop, o_burst_stop);
                    check_field("burst_ordinal", head_burst.burst_ordinal,
                                o_burst_ordinal);
                    check_field("final_of_item", {31'd0, head_burst.final_of_item},
                                {31'd0, o_final_of_item});
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Driver: photon requests in bursts of random length with random gaps.
    // A stalled request holds its payload.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_photons.size() != 0) begin
                next_photon = pending_photons.pop_front();
                i_valid         <= 1'b1;
                i_arrival_time  <= next_photon.arrival;
                i_end_of_stream <= next_photon.eos;
                if (burst_left == 0)   // now and then a long unbroken stretch
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                burst_left = burst_left - 1;
                if (burst_left == 0)
                    send_gap = $urandom_range(1, 6);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: alternating stall/free runs, occasional long free stretches,
    // and a long hold-off whenever a new ticket is issued.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left   = LONG_HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (pattern_left > 0) begin
            pattern_left = pattern_left - 1;
        end else if (i_stall) begin
            i_stall <= 1'b0;
            pattern_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                       : $urandom_range(0, 20);
        end else begin
            i_stall <= 1'b1;
            pattern_left = $urandom_range(0, 7);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("interphoton_gap_burst_search test failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    task automatic push_photon(input logic [63:0] t, input logic eos);
        t_photon ph;
        ph.arrival = t;
        ph.eos     = eos;
        pending_photons.push_back(ph);
        phase_count++;
    endtask

    // sender idle and every report in, then a few spare cycles
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_photons.size() != 0 || i_valid || expected_bursts.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // both thresholds, back to back on the config channel
    task automatic write_regs(input logic [31:0] gap, input logic [31:0] minp);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= igbs_pkg::RegMaxGap;
        i_cfg_data  <= gap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= igbs_pkg::RegMinSize;
        i_cfg_data  <= minp;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        gen_max_gap = gap;
        gen_min     = minp;
        @(negedge i_clk);
    endtask

    // gap that keeps the run going
    function automatic logic [63:0] inside_gap();
        case ($urandom_range(0, 3))
            0:       return 64'd0;
            1:       return {32'd0, gen_max_gap};
            default: return {32'd0, $urandom_range(0, gen_max_gap)};
        endcase
    endfunction

    // gap that normally breaks the run; backwards steps wrap to huge gaps
    function automatic logic [63:0] breaking_gap();
        case ($urandom_range(0, 4))
            0:       return {32'd0, gen_max_gap} + 64'd1;
            1:       return {32'd0, gen_max_gap} + 64'd1 + $urandom_range(0, 1000);
            2:       return {$urandom, $urandom};
            3:       return 64'd0 - $urandom_range(1, 1000);
            default: return {32'd0, gen_max_gap} + 64'd1 + {$urandom, 16'd0};
        endcase
    endfunction

    // one stream: clusters of close photons split by breaking gaps, with a
    // sprinkling of fully random timestamps as noise
    task automatic queue_stream(input bit close_it);
        int clusters;
        int len;
        int c;
        int k;
        clusters = $urandom_range(1, 5);
        case ($urandom_range(0, 3))
            0:       gen_time = 64'd0;
            1:       gen_time = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 4000);
            default: gen_time = {$urandom, $urandom};
        endcase
        for (c = 0; c < clusters; c++) begin
            len = (gen_min <= 40) ? $urandom_range(1, gen_min + 3) : $urandom_range(1, 20);
            if ($urandom_range(0, 7) == 0)
                len += $urandom_range(0, 40);
            for (k = 0; k < len; k++) begin
                if (k == 0 && c != 0)
                    gen_time = gen_time + breaking_gap();
                else if (k != 0)
                    gen_time = gen_time + inside_gap();
                if ($urandom_range(0, 15) == 0)
                    gen_time = {$urandom, $urandom};
                push_photon(gen_time, close_it && c == clusters - 1 && k == len - 1);
            end
        end
    endtask

    // settle, reprogram, queue about target photons; streams mostly closed
    task automatic run_phase(input logic [31:0] gap, input logic [31:0] minp,
                             input int target, input bit long_hold);
        wait_drained();
        write_regs(gap, minp);
        phase_count = 0;
        while (phase_count < target)
            queue_stream($urandom_range(0, 3) != 0);
        // receiver holds off while the sender keeps offering, so the result
        // queue fills and the input stalls
        if (long_hold)
            hold_ticket++;
    endtask

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset thresholds: run of eleven at exactly max_gap wrapping past
        // 2^64, broken by a backwards step, then a lone closing photon
        gen_time = 64'hFFFF_FFFF_FFFF_FE00;
        push_photon(gen_time, 1'b0);
        repeat (10) begin
            gen_time = gen_time + 64'd500;
            push_photon(gen_time, 1'b0);
        end
        push_photon(64'd0, 1'b0);
        push_photon(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        wait_drained();

        // zero gap allowed, single photons count: equal times stay, a step of
        // one breaks, a first photon with end of stream, break plus close
        write_regs(32'd0, 32'd1);
        push_photon(64'd5, 1'b0);
        push_photon(64'd5, 1'b0);
        push_photon(64'd6, 1'b0);
        push_photon(64'd6, 1'b1);
        push_photon(64'd7, 1'b1);
        push_photon(64'd9, 1'b0);
        push_photon(64'd3, 1'b1);
        wait_drained();

        // widest gap, every run reported: gap of 2^32-1 stays, 2^32 breaks
        write_regs(32'hFFFF_FFFF, 32'd0);
        push_photon(64'd0, 1'b0);
        push_photon(64'h0000_0000_FFFF_FFFF, 1'b0);
        push_photon(64'h0000_0001_FFFF_FFFF, 1'b0);
        push_photon(64'h0000_0001_FFFF_FFFF, 1'b1);

        // random phases across the threshold range
        run_phase(igbs_pkg::MaxGapReset, igbs_pkg::MinSizeReset, 120, 1'b0);
        run_phase(32'd0, 32'd1, 80, 1'b0);
        run_phase(32'd1000, 32'd1, 120, 1'b1);
        run_phase(32'hFFFF_FFFF, 32'd3, 80, 1'b0);
        run_phase($urandom_range(0, 2000), $urandom_range(1, 12), 120, 1'b0);
        run_phase(32'd100, 32'hFFFF_FFFF, 40, 1'b0);
        run_phase(32'd50, 32'd2, 120, 1'b1);
        run_phase($urandom, $urandom_range(0, 6), 120, 1'b0);

        wait_drained();
        if (error_count == 0)
            $display("interphoton_gap_burst_search test passed");
        else
            $display("interphoton_gap_burst_search test failed");
        $finish;
    end

endmodule
